// File: src/hsv_to_rgb_converter_macros.svh
// Assertion macros shared by the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HSV_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HSV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/hsv2rgb_pkg.sv
// Shared constants and types of the HSV to RGB converter.
package hsv2rgb_pkg;

	localparam int DEF_HUE_FRAC_BITS = 6;
	localparam int DEF_CHANNEL_BITS  = 8;

	// fractional bits carried by chroma, second component and offset
	localparam int FRAC_BITS  = 8;
	// integer degrees of hue, 0..511
	localparam int DEG_W      = 9;
	// degrees in one sextant and the bits that hold them
	localparam int SEXT_DEG   = 60;
	localparam int SEXT_DEG_W = 6;
	// sextant index, counts past five for hue at or above 360 degrees
	localparam int SEXT_W     = 4;
	localparam int ALPHA_W    = 8;

	localparam logic [SEXT_W-1:0] SX_RED    = 4'd0;
	localparam logic [SEXT_W-1:0] SX_YELLOW = 4'd1;
	localparam logic [SEXT_W-1:0] SX_GREEN  = 4'd2;
	localparam logic [SEXT_W-1:0] SX_CYAN   = 4'd3;
	localparam logic [SEXT_W-1:0] SX_BLUE   = 4'd4;

	// pipeline stages
	localparam int NUM_STAGES = 5;
	localparam int ST_HUE     = 0;
	localparam int ST_CHROMA  = 1;
	localparam int ST_MUL     = 2;
	localparam int ST_RECIP   = 3;
	localparam int ST_OUT     = 4;

	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic [NUM_STAGES-1:0] valid;
	} pipe_ctl_t;

endpackage

// File: src/hsv2rgb_pipe_ctl.sv
// Valid bits and per-stage load enables of the converter pipeline.
module hsv2rgb_pipe_ctl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   out_ready,
	output logic                   in_ready,
	output logic                   out_valid,
	output hsv2rgb_pkg::pipe_ctl_t ctl
);
	import hsv2rgb_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] load;

	// a stage loads when it is empty or its successor moves on
	always_comb begin
		load[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			load[k] = !valid_q[k] || load[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (load[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign in_ready  = load[0];
	assign out_valid = valid_q[NUM_STAGES-1];
	assign ctl.load  = load;
	assign ctl.valid = valid_q;

endmodule

// File: src/hsv2rgb_chroma.sv
// Front stages: hue split into sextant and weight, then chroma as quotient and remainder.
module hsv2rgb_chroma #(
	parameter int HUE_FRAC_BITS = hsv2rgb_pkg::DEF_HUE_FRAC_BITS,
	parameter int CHANNEL_BITS  = hsv2rgb_pkg::DEF_CHANNEL_BITS
) (
	input  logic                                                  clk,
	input  hsv2rgb_pkg::pipe_ctl_t                                ctl,
	input  logic [HUE_FRAC_BITS+hsv2rgb_pkg::DEG_W-1:0]           hue,
	input  logic [CHANNEL_BITS-1:0]                               saturation,
	input  logic [CHANNEL_BITS-1:0]                               brightness,
	input  logic [hsv2rgb_pkg::ALPHA_W-1:0]                       alpha_in,
	output logic [CHANNEL_BITS-1:0]                               quot_s2,
	output logic [CHANNEL_BITS-1:0]                               rmdr_s2,
	output logic [HUE_FRAC_BITS+hsv2rgb_pkg::SEXT_DEG_W-1:0]      weight_s2,
	output logic [hsv2rgb_pkg::SEXT_W-1:0]                        sext_s2,
	output logic [CHANNEL_BITS-1:0]                               val_s2,
	output logic [hsv2rgb_pkg::ALPHA_W-1:0]                       alpha_s2
);
	import hsv2rgb_pkg::*;

	localparam int HW       = HUE_FRAC_BITS + DEG_W;
	localparam int REM_W    = HUE_FRAC_BITS + SEXT_DEG_W;
	localparam int CB       = CHANNEL_BITS;
	localparam int MAX_SEXT = ((1 << DEG_W) - 1) / SEXT_DEG;
	localparam logic [REM_W-1:0] SEXT_UNITS = REM_W'(SEXT_DEG) << HUE_FRAC_BITS;

	logic [DEG_W-1:0]  deg;
	logic [SEXT_W-1:0] sext;
	logic [DEG_W-1:0]  sext_deg;
	logic [HW-1:0]     rem_full;
	logic [REM_W-1:0]  rem;
	logic [REM_W-1:0]  weight;
	logic [2*CB-1:0]   prod;

	logic [SEXT_W-1:0] sext_s1;
	logic [REM_W-1:0]  weight_s1;
	logic [2*CB-1:0]   prod_s1;
	logic [CB-1:0]     val_s1;
	logic [ALPHA_W-1:0] alpha_s1;

	logic [2*CB:0]     quot_sum;
	logic [CB-1:0]     quot;
	logic [2*CB-1:0]   rmdr_full;

	// sextant by threshold compares on whole degrees
	always_comb begin
		deg  = hue[HW-1 -: DEG_W];
		sext = '0;
		for (int j = 1; j <= MAX_SEXT; j++) begin
			if (deg >= DEG_W'(j * SEXT_DEG)) begin
				sext = sext + SEXT_W'(1);
			end
		end
		sext_deg = DEG_W'(sext) * DEG_W'(SEXT_DEG);
		rem_full = hue - (HW'(sext_deg) << HUE_FRAC_BITS);
		rem      = rem_full[REM_W-1:0];
		weight   = sext[0] ? (SEXT_UNITS - rem) : rem;
		prod     = (2*CB)'(brightness) * (2*CB)'(saturation);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[ST_HUE]) begin
			sext_s1   <= sext;
			weight_s1 <= weight;
			prod_s1   <= prod;
			val_s1    <= brightness;
			alpha_s1  <= alpha_in;
		end
	end

	// divide by 2^CB-1: exact for every product of two CB-bit channels
	always_comb begin
		quot_sum  = (2*CB+1)'(prod_s1) + (2*CB+1)'(prod_s1 >> CB) + (2*CB+1)'(1);
		quot      = quot_sum[2*CB-1:CB];
		rmdr_full = prod_s1 - {quot, {CB{1'b0}}} + (2*CB)'(quot);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[ST_CHROMA]) begin
			quot_s2   <= quot;
			rmdr_s2   <= rmdr_full[CB-1:0];
			weight_s2 <= weight_s1;
			sext_s2   <= sext_s1;
			val_s2    <= val_s1;
			alpha_s2  <= alpha_s1;
		end
	end

endmodule

// File: src/hsv2rgb_mix.sv
// Back stages: chroma times weight, divide by the sextant size, place and offset channels.
module hsv2rgb_mix #(
	parameter int HUE_FRAC_BITS = hsv2rgb_pkg::DEF_HUE_FRAC_BITS,
	parameter int CHANNEL_BITS  = hsv2rgb_pkg::DEF_CHANNEL_BITS
) (
	input  logic                                             clk,
	input  hsv2rgb_pkg::pipe_ctl_t                           ctl,
	input  logic [CHANNEL_BITS-1:0]                          quot_s2,
	input  logic [CHANNEL_BITS-1:0]                          rmdr_s2,
	input  logic [HUE_FRAC_BITS+hsv2rgb_pkg::SEXT_DEG_W-1:0] weight_s2,
	input  logic [hsv2rgb_pkg::SEXT_W-1:0]                   sext_s2,
	input  logic [CHANNEL_BITS-1:0]                          val_s2,
	input  logic [hsv2rgb_pkg::ALPHA_W-1:0]                  alpha_s2,
	output logic [CHANNEL_BITS-1:0]                          red,
	output logic [CHANNEL_BITS-1:0]                          green,
	output logic [CHANNEL_BITS-1:0]                          blue,
	output logic [hsv2rgb_pkg::ALPHA_W-1:0]                  alpha_out
);
	import hsv2rgb_pkg::*;

	localparam int CB        = CHANNEL_BITS;
	localparam int REM_W     = HUE_FRAC_BITS + SEXT_DEG_W;
	localparam int C_W       = CB + FRAC_BITS;
	localparam int PROD_W    = C_W + REM_W;
	// sixty is four times fifteen: shift out the four, multiply by 1/15
	localparam int DIV_SHIFT = 2;
	localparam int DIV_ODD   = SEXT_DEG >> DIV_SHIFT;
	localparam int XN        = PROD_W - HUE_FRAC_BITS - DIV_SHIFT;
	localparam int RECIP_SH  = XN + $clog2(DIV_ODD);
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << RECIP_SH) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD);
	localparam logic [XN:0] RECIP = RECIP_FULL[XN:0];

	logic [3*CB-1:0]    frac_rep;
	logic [C_W-1:0]     chroma;

	logic [C_W-1:0]     chroma_s3;
	logic [C_W-1:0]     offs_s3;
	logic [PROD_W-1:0]  prod_s3;
	logic [SEXT_W-1:0]  sext_s3;
	logic [ALPHA_W-1:0] alpha_s3;

	logic [XN-1:0]      scaled;
	logic [2*XN:0]      recip_prod;

	logic [C_W-1:0]     second_s4;
	logic [C_W-1:0]     chroma_s4;
	logic [C_W-1:0]     offs_s4;
	logic [SEXT_W-1:0]  sext_s4;
	logic [ALPHA_W-1:0] alpha_s4;

	logic [C_W-1:0]     pr;
	logic [C_W-1:0]     pg;
	logic [C_W-1:0]     pb;
	logic [C_W-1:0]     sum_r;
	logic [C_W-1:0]     sum_g;
	logic [C_W-1:0]     sum_b;

	logic [CB-1:0]      red_s5;
	logic [CB-1:0]      green_s5;
	logic [CB-1:0]      blue_s5;
	logic [ALPHA_W-1:0] alpha_s5;

	// rmdr/(2^CB-1) in binary is rmdr repeated, so its fraction bits are the top bits
	always_comb begin
		frac_rep = {rmdr_s2, rmdr_s2, rmdr_s2};
		chroma   = {quot_s2, frac_rep[3*CB-1 -: FRAC_BITS]};
	end

	always_ff @(posedge clk) begin
		if (ctl.load[ST_MUL]) begin
			chroma_s3 <= chroma;
			offs_s3   <= {val_s2, {FRAC_BITS{1'b0}}} - chroma;
			prod_s3   <= PROD_W'(chroma) * PROD_W'(weight_s2);
			sext_s3   <= sext_s2;
			alpha_s3  <= alpha_s2;
		end
	end

	always_comb begin
		scaled     = prod_s3[PROD_W-1 -: XN];
		recip_prod = (2*XN+1)'(scaled) * (2*XN+1)'(RECIP);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[ST_RECIP]) begin
			second_s4 <= recip_prod[RECIP_SH +: C_W];
			chroma_s4 <= chroma_s3;
			offs_s4   <= offs_s3;
			sext_s4   <= sext_s3;
			alpha_s4  <= alpha_s3;
		end
	end

	always_comb begin
		case (sext_s4)
			SX_RED: begin
				pr = chroma_s4; pg = second_s4; pb = '0;
			end
			SX_YELLOW: begin
				pr = second_s4; pg = chroma_s4; pb = '0;
			end
			SX_GREEN: begin
				pr = '0; pg = chroma_s4; pb = second_s4;
			end
			SX_CYAN: begin
				pr = '0; pg = second_s4; pb = chroma_s4;
			end
			SX_BLUE: begin
				pr = second_s4; pg = '0; pb = chroma_s4;
			end
			default: begin
				pr = chroma_s4; pg = '0; pb = second_s4;
			end
		endcase
		sum_r = pr + offs_s4;
		sum_g = pg + offs_s4;
		sum_b = pb + offs_s4;
	end

	always_ff @(posedge clk) begin
		if (ctl.load[ST_OUT]) begin
			red_s5   <= sum_r[C_W-1 -: CB];
			green_s5 <= sum_g[C_W-1 -: CB];
			blue_s5  <= sum_b[C_W-1 -: CB];
			alpha_s5 <= alpha_s4;
		end
	end

	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;
	assign alpha_out = alpha_s5;

endmodule

// File: src/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB pixel converter.
//
// Converts one HSV pixel per transaction into RGB with alpha passed through.
// The block takes a new pixel on every clock unless a full pipeline is stalled
// by m_axis_tready; each result is carried through the five register stages
// (hue split and value times saturation, chroma division, chroma times hue
// weight, reciprocal multiply for the division by the sextant size, channel
// placement and offset). Each stage holds its own valid bit, so a stall on
// m_axis_tready backs up only the stages that are full and empty stages keep
// taking pixels. Hue is in 1/2^HUE_FRAC_BITS degree units; hue at or above
// 360 degrees keeps counting sextants and is placed with the last sextant's
// pattern. Channels are truncated toward zero and never exceed brightness.
// Input tdata, from bit 0: hue, saturation, brightness, alpha_in, zero pad.
// Output tdata, from bit 0: red, green, blue, alpha_out, zero pad.
module hsv_to_rgb_converter #(
	parameter int HUE_FRAC_BITS = hsv2rgb_pkg::DEF_HUE_FRAC_BITS,
	parameter int CHANNEL_BITS  = hsv2rgb_pkg::DEF_CHANNEL_BITS,
	localparam int HUE_W  = HUE_FRAC_BITS + hsv2rgb_pkg::DEG_W,
	localparam int IN_W   =
		((HUE_W + 2 * CHANNEL_BITS + hsv2rgb_pkg::ALPHA_W + 7) / 8) * 8,
	localparam int OUT_W  =
		((3 * CHANNEL_BITS + hsv2rgb_pkg::ALPHA_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// hue, saturation, brightness, alpha_in (lowest bit up), zero pad
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// red, green, blue, alpha_out (lowest bit up), zero pad
	output logic [OUT_W-1:0] m_axis_tdata
);
	import hsv2rgb_pkg::*;

	`include "hsv_to_rgb_converter_macros.svh"

	localparam int CB      = CHANNEL_BITS;
	localparam int REM_W   = HUE_FRAC_BITS + SEXT_DEG_W;
	localparam int SAT_LO  = HUE_W;
	localparam int VAL_LO  = HUE_W + CB;
	localparam int ALPH_LO = HUE_W + 2 * CB;

	pipe_ctl_t ctl;

	// unpacked input fields; pad bits above alpha_in are dropped
	logic [HUE_W-1:0]   hue;
	logic [CB-1:0]      saturation;
	logic [CB-1:0]      brightness;
	logic [ALPHA_W-1:0] alpha_in;

	// chroma front to back
	logic [CB-1:0]      quot_s2;
	logic [CB-1:0]      rmdr_s2;
	logic [REM_W-1:0]   weight_s2;
	logic [SEXT_W-1:0]  sext_s2;
	logic [CB-1:0]      val_s2;
	logic [ALPHA_W-1:0] alpha_s2;

	// result fields
	logic [CB-1:0]      red;
	logic [CB-1:0]      green;
	logic [CB-1:0]      blue;
	logic [ALPHA_W-1:0] alpha_out;

	assign hue        = s_axis_tdata[HUE_W-1:0];
	assign saturation = s_axis_tdata[SAT_LO +: CB];
	assign brightness = s_axis_tdata[VAL_LO +: CB];
	assign alpha_in   = s_axis_tdata[ALPH_LO +: ALPHA_W];

	// Handshake control: per-stage valid bits and load enables.
	hsv2rgb_pipe_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.out_ready (m_axis_tready),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.ctl       (ctl)
	);

	// Stages one and two: sextant, hue weight, chroma quotient and remainder.
	hsv2rgb_chroma #(
		.HUE_FRAC_BITS (HUE_FRAC_BITS),
		.CHANNEL_BITS  (CHANNEL_BITS)
	) u_chroma (
		.clk        (clk),
		.ctl        (ctl),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.alpha_in   (alpha_in),
		.quot_s2    (quot_s2),
		.rmdr_s2    (rmdr_s2),
		.weight_s2  (weight_s2),
		.sext_s2    (sext_s2),
		.val_s2     (val_s2),
		.alpha_s2   (alpha_s2)
	);

	// Stages three to five: second component, placement, offset, truncation.
	hsv2rgb_mix #(
		.HUE_FRAC_BITS (HUE_FRAC_BITS),
		.CHANNEL_BITS  (CHANNEL_BITS)
	) u_mix (
		.clk       (clk),
		.ctl       (ctl),
		.quot_s2   (quot_s2),
		.rmdr_s2   (rmdr_s2),
		.weight_s2 (weight_s2),
		.sext_s2   (sext_s2),
		.val_s2    (val_s2),
		.alpha_s2  (alpha_s2),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.alpha_out (alpha_out)
	);

	// pack result fields, zero pad to whole bytes
	assign m_axis_tdata = OUT_W'({alpha_out, blue, green, red});

	// Back-pressure reaches the input only when every stage holds a pixel.
	`HSV_ASSERT_IMPL(a_ready_only_when_full, !s_axis_tready, ctl.valid == '1, "input stalled with a free stage")
	// An accepted transaction occupies the first stage on the next cycle.
	`HSV_ASSERT_NEXT(a_accept_fills_first, s_axis_tvalid && s_axis_tready, ctl.valid[ST_HUE], "accepted pixel lost at first stage")

endmodule

// File: tb/pixel_color_checker.sv
// Checker that predicts RGB pixels from accepted HSV pixels and compares them with the converter.
`timescale 1ns / 100ps
module pixel_color_checker #(
	parameter int HUE_W = 15,
	parameter int CH_W  = 8,
	parameter int IN_W  = 40,
	parameter int OUT_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	input  logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,
	input  logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	input  logic [OUT_W-1:0] m_axis_tdata,
	output int               fail_count,
	output int               colors_waiting
);
	import hsv2rgb_pkg::*;

	localparam int HUE_FRAC = HUE_W - DEG_W;
	localparam longint unsigned SEXT_UNITS = longint'(SEXT_DEG) << HUE_FRAC;
	localparam longint unsigned CH_MAX = (64'd1 << CH_W) - 1;

	typedef struct packed {
		logic [CH_W-1:0]    red;
		logic [CH_W-1:0]    green;
		logic [CH_W-1:0]    blue;
		logic [ALPHA_W-1:0] alpha;
	} rgba_t;

	rgba_t expected_colors[$];

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_channel(input string name, input longint unsigned got_v,
			input longint unsigned want_v);
		if (got_v != want_v)
			report_mismatch($sformatf("%s is %0d, want %0d", name, got_v, want_v));
	endtask

	// Fixed-point HSV to RGB with 8 fractional bits in chroma, second and offset.
	function automatic rgba_t convert_pixel(input logic [IN_W-1:0] word);
		longint unsigned hue, sat, bright, rem, wgt, chroma, second, offset;
		longint unsigned red_f, green_f, blue_f;
		logic [SEXT_W-1:0] sext;
		rgba_t px;
		hue    = 64'(word[HUE_W-1:0]);
		sat    = 64'(word[HUE_W +: CH_W]);
		bright = 64'(word[HUE_W+CH_W +: CH_W]);
		sext   = SEXT_W'(hue / SEXT_UNITS);
		rem    = hue % SEXT_UNITS;
		// odd sextants fall from full chroma, even ones rise toward it
		wgt    = sext[0] ? SEXT_UNITS - rem : rem;
		chroma = ((bright * sat) << FRAC_BITS) / CH_MAX;
		second = (chroma * wgt) / SEXT_UNITS;
		offset = (bright << FRAC_BITS) - chroma;
		case (sext)
			SX_RED: begin
				red_f = chroma; green_f = second; blue_f = 0;
			end
			SX_YELLOW: begin
				red_f = second; green_f = chroma; blue_f = 0;
			end
			SX_GREEN: begin
				red_f = 0; green_f = chroma; blue_f = second;
			end
			SX_CYAN: begin
				red_f = 0; green_f = second; blue_f = chroma;
			end
			SX_BLUE: begin
				red_f = second; green_f = 0; blue_f = chroma;
			end
			// magenta and every sextant past a full turn
			default: begin
				red_f = chroma; green_f = 0; blue_f = second;
			end
		endcase
		px.red   = CH_W'((red_f + offset) >> FRAC_BITS);
		px.green = CH_W'((green_f + offset) >> FRAC_BITS);
		px.blue  = CH_W'((blue_f + offset) >> FRAC_BITS);
		px.alpha = word[HUE_W+2*CH_W +: ALPHA_W];
		return px;
	endfunction

	always @(posedge clk) begin
		rgba_t got, want;
		if (!arst_n) begin
			fail_count     = 0;
			colors_waiting = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_colors.push_back(convert_pixel(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got.red   = m_axis_tdata[0 +: CH_W];
				got.green = m_axis_tdata[CH_W +: CH_W];
				got.blue  = m_axis_tdata[2*CH_W +: CH_W];
				got.alpha = m_axis_tdata[3*CH_W +: ALPHA_W];
				if (expected_colors.size() == 0) begin
					report_mismatch($sformatf("pixel %h with none pending", m_axis_tdata));
				end else begin
					want = expected_colors.pop_front();
					check_channel("red", 64'(got.red), 64'(want.red));
					check_channel("green", 64'(got.green), 64'(want.green));
					check_channel("blue", 64'(got.blue), 64'(want.blue));
					check_channel("alpha_out", 64'(got.alpha), 64'(want.alpha));
				end
			end
			colors_waiting = expected_colors.size();
		end
	end

endmodule

// File: tb/testbench.sv
// Top of the HSV to RGB converter testbench: clock, reset, pixel stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
	import hsv2rgb_pkg::*;

	localparam int HUE_FRAC  = DEF_HUE_FRAC_BITS;
	localparam int CH_W      = DEF_CHANNEL_BITS;
	localparam int HUE_W     = HUE_FRAC + DEG_W;
	localparam int IN_W      = ((HUE_W + 2 * CH_W + ALPHA_W + 7) / 8) * 8;
	localparam int OUT_W     = ((3 * CH_W + ALPHA_W + 7) / 8) * 8;
	// hue units in one sextant and the first unit at a full turn
	localparam int SEXT_UNITS    = SEXT_DEG << HUE_FRAC;
	localparam int HUE_FULL_TURN = 360 << HUE_FRAC;
	localparam int HUE_FIELD_MAX = (1 << HUE_W) - 1;
	localparam int RESET_CYCLES  = 11;
	// pipeline is five stages deep; leave room for a stray late result
	localparam int DRAIN_CYCLES  = 4 * NUM_STAGES;
	localparam int PHASE_ITEMS   = 630;
	// cycles with no transaction on either side before the run is declared hung
	localparam int STALL_LIMIT   = 2000;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	// hue, saturation, brightness, alpha_in (lowest bit up), zero pad
	logic [IN_W-1:0]  s_axis_tdata  = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	// red, green, blue, alpha_out (lowest bit up), zero pad
	logic [OUT_W-1:0] m_axis_tdata;

	int fail_count;
	int colors_waiting;
	int send_idle_pct = 32;
	int recv_idle_pct = 82;
	int quiet_cycles  = 0;

	always #5 clk = ~clk;

	hsv_to_rgb_converter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	pixel_color_checker #(
		.HUE_W (HUE_W),
		.CH_W  (CH_W),
		.IN_W  (IN_W),
		.OUT_W (OUT_W)
	) color_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.fail_count     (fail_count),
		.colors_waiting (colors_waiting)
	);

	// Receiver side: drop tready at random according to the current idle share.
	always @(posedge clk) begin
		if (arst_n)
			m_axis_tready <= $urandom_range(99) >= recv_idle_pct;
	end

	// Watchdog: end the run when no transaction moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one pixel, idling first at random; return once the transaction is taken.
	// Only one assignment to tvalid lands in any time step.
	task automatic send_pixel(input int hue, input int sat, input int bright, input int alpha);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_W'({ALPHA_W'(alpha), CH_W'(bright), CH_W'(sat), HUE_W'(hue)});
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Channel level with the extremes weighted up.
	function automatic logic [CH_W-1:0] random_level();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return CH_W'($urandom());
		endcase
	endfunction

	initial begin
		int hue;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: sextant edges, gray and black, channel extremes, hue past a full turn.
		send_pixel(0, 255, 255, 0);
		send_pixel(SEXT_UNITS - 1, 255, 255, 255);
		send_pixel(SEXT_UNITS, 255, 255, 128);
		send_pixel(SEXT_UNITS + SEXT_UNITS / 2, 200, 180, 1);
		send_pixel(2 * SEXT_UNITS, 255, 255, 2);
		send_pixel(2 * SEXT_UNITS + 100, 0, 200, 17);
		send_pixel(3 * SEXT_UNITS + 5, 255, 0, 255);
		send_pixel(3 * SEXT_UNITS + SEXT_UNITS / 2, 128, 255, 64);
		send_pixel(4 * SEXT_UNITS, 255, 255, 32);
		send_pixel(4 * SEXT_UNITS + 1234, 1, 1, 99);
		send_pixel(5 * SEXT_UNITS, 255, 1, 200);
		send_pixel(5 * SEXT_UNITS + SEXT_UNITS / 3, 90, 240, 77);
		send_pixel(HUE_FULL_TURN - 1, 255, 255, 255);
		send_pixel(HUE_FULL_TURN, 200, 180, 8);
		send_pixel(HUE_FULL_TURN + SEXT_UNITS / 2, 255, 255, 9);
		send_pixel(HUE_FULL_TURN + SEXT_UNITS + 7, 255, 255, 10);
		send_pixel(HUE_FIELD_MAX, 255, 255, 170);
		send_pixel(HUE_FIELD_MAX, 0, 0, 85);
		send_pixel(SEXT_UNITS / 2, 255, 255, 0);

		// Random: three idle settings, the last with steady flow on both sides.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 32; recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82; recv_idle_pct = 32;
				end
				default: begin
					send_idle_pct = 0; recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// mostly hue within a turn, the rest at or past a full turn
				if ($urandom_range(99) < 85)
					hue = int'($urandom_range(HUE_FULL_TURN - 1));
				else
					hue = int'($urandom_range(HUE_FIELD_MAX, HUE_FULL_TURN));
				send_pixel(hue, int'(random_level()), int'(random_level()),
					int'($urandom_range(255)));
			end
		end
		s_axis_tvalid <= 1'b0;

		// Hold until every predicted pixel is back, then watch a little longer.
		@(posedge clk);
		wait (colors_waiting == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/hsv2rgb_pkg.sv
src/hsv2rgb_pipe_ctl.sv
src/hsv2rgb_chroma.sv
src/hsv2rgb_mix.sv
src/hsv_to_rgb_converter.sv
tb/pixel_color_checker.sv
tb/testbench.sv
